// ===== rtl/slfr_pkg.sv =====
// Shared types, constants and the frame classifier for the sync/length frame receiver.
// No dependencies; every other file in rtl/ imports this package.
package slfr_pkg;

   // Frame geometry
   localparam int MAX_PAYLOAD   = 16;
   localparam int HDR_LEN       = 3;
   localparam int STORE_DEPTH   = MAX_PAYLOAD + HDR_LEN;
   localparam int NUM_BANKS     = 2;
   localparam int BANK_W        = $clog2(NUM_BANKS);
   localparam int IDX_W         = $clog2(STORE_DEPTH);
   localparam int CNT_W         = $clog2(STORE_DEPTH + 1);
   localparam int LEN_W         = $clog2(MAX_PAYLOAD + 1);
   localparam int CMDQ_DEPTH    = 2;
   localparam int CMDQ_PTR_W    = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W    = $clog2(CMDQ_DEPTH + 1);

   // Fixed field widths
   localparam int BYTE_W        = 8;
   localparam int INDEX_W       = 5;
   localparam int KIND_W        = 3;
   localparam int STATUS_W      = 2;
   localparam int CSR_IDX_W     = 3;

   // Frame positions used by the classifier
   localparam int POS_LEN       = 1;
   localparam int POS_ID        = 2;
   localparam int POS_EVENT     = 4;
   localparam int POS_CODE      = 5;
   localparam logic [BYTE_W-1:0] CHANNEL_EVENT = 8'd1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SYNC_VALUE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_EVENT_MSG_ID   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BCAST_MSG_ID   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NO_ERROR_CODE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SEARCH_TO_CODE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RX_FAIL_CODE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TX_DONE_CODE   = 3'd6;

   typedef enum logic [KIND_W-1:0] {
      KIND_IGNORE    = 3'd0,
      KIND_SEARCH_TO = 3'd1,
      KIND_TX_DONE   = 3'd2,
      KIND_BROADCAST = 3'd3,
      KIND_UNHANDLED = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_GOOD     = 2'd0,
      ST_CSUM_ERR = 2'd1,
      ST_LEN_OVF  = 2'd2
   } status_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] sync_value;
      logic [BYTE_W-1:0] event_msg_id;
      logic [BYTE_W-1:0] bcast_msg_id;
      logic [BYTE_W-1:0] no_error_code;
      logic [BYTE_W-1:0] search_to_code;
      logic [BYTE_W-1:0] rx_fail_code;
      logic [BYTE_W-1:0] tx_done_code;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      sync_value:     8'd164,
      event_msg_id:   8'd64,
      bcast_msg_id:   8'd78,
      no_error_code:  8'd0,
      search_to_code: 8'd1,
      rx_fail_code:   8'd2,
      tx_done_code:   8'd3
   };

   // One entry of the front-to-back queue
   typedef struct packed {
      status_type         status;
      kind_type           kind;
      logic [IDX_W-1:0]   last_pos;
      logic [BANK_W-1:0]  bank;
   } cmd_type;

   // Frame store write from the front
   typedef struct packed {
      logic               en;
      logic [BANK_W-1:0]  bank;
      logic [IDX_W-1:0]   idx;
      logic [BYTE_W-1:0]  data;
   } mem_wr_type;

   // Bank handed back by the back part once its last byte is read
   typedef struct packed {
      logic               valid;
      logic [BANK_W-1:0]  bank;
   } release_type;

   function automatic kind_type slfr_classify(
      input logic [BYTE_W-1:0] id,
      input logic [BYTE_W-1:0] ev,
      input logic [BYTE_W-1:0] code,
      input cfg_type           cfg
   );
      kind_type k;
      k = KIND_UNHANDLED;
      if (id == cfg.event_msg_id) begin
         if (ev != CHANNEL_EVENT)                k = KIND_UNHANDLED;
         else if (code == cfg.no_error_code)     k = KIND_IGNORE;
         else if (code == cfg.search_to_code)    k = KIND_SEARCH_TO;
         else if (code == cfg.rx_fail_code)      k = KIND_IGNORE;
         else if (code == cfg.tx_done_code)      k = KIND_TX_DONE;
         else                                    k = KIND_UNHANDLED;
      end else if (id == cfg.bcast_msg_id) begin
         k = KIND_BROADCAST;
      end
      return k;
   endfunction

endpackage

// ===== rtl/slfr_front.sv =====
// Front part: config registers, sync hunt, length check, checksum, classification.
// Depends on slfr_pkg; writes the frame store in slfr_back and pushes slfr_cmd_fifo.
module slfr_front
   import slfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [BYTE_W-1:0]     req_rx_byte,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [BYTE_W-1:0]     csr_wdata,
   input  logic                  q_full,
   output logic                  q_push,
   output cmd_type               q_cmd,
   output mem_wr_type            mem_wr,
   input  release_type           rel
);

   cfg_type                cfg_ff;
   logic                   in_frame_ff, in_frame_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [BYTE_W-1:0]      xor_ff, xor_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [BYTE_W-1:0]      id_ff, id_in;
   logic [BYTE_W-1:0]      ev_ff, ev_in;
   logic [BYTE_W-1:0]      code_ff, code_in;
   logic [BANK_W-1:0]      wbank_ff, wbank_in;
   logic [NUM_BANKS-1:0]   busy_ff, busy_in;

   logic                   accept;
   logic [CNT_W:0]         limit;

   assign req_full = busy_ff[wbank_ff] || q_full;
   assign accept   = req_push && !req_full;
   assign limit    = (CNT_W+1)'(len_ff) + (CNT_W+1)'(HDR_LEN);

   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      xor_in      = xor_ff;
      len_in      = len_ff;
      id_in       = id_ff;
      ev_in       = ev_ff;
      code_in     = code_ff;
      wbank_in    = wbank_ff;
      busy_in     = busy_ff;
      q_push      = 1'b0;
      q_cmd.status   = ST_GOOD;
      q_cmd.kind     = KIND_IGNORE;
      q_cmd.last_pos = '0;
      q_cmd.bank     = wbank_ff;
      mem_wr.en   = 1'b0;
      mem_wr.bank = wbank_ff;
      mem_wr.idx  = IDX_W'(count_ff);
      mem_wr.data = req_rx_byte;

      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end

      if (accept) begin
         if (!in_frame_ff) begin
            // hunt: drop everything but sync
            if (req_rx_byte == cfg_ff.sync_value) begin
               in_frame_in = 1'b1;
               count_in    = CNT_W'(1);
               xor_in      = req_rx_byte;
               id_in       = '0;
               ev_in       = '0;
               code_in     = '0;
               mem_wr.en   = 1'b1;
               mem_wr.idx  = '0;
            end
         end else if (count_ff == CNT_W'(POS_LEN)) begin
            if (req_rx_byte > BYTE_W'(MAX_PAYLOAD)) begin
               in_frame_in  = 1'b0;
               count_in     = '0;
               xor_in       = '0;
               q_push       = 1'b1;
               q_cmd.status = ST_LEN_OVF;
            end else begin
               len_in    = LEN_W'(req_rx_byte);
               xor_in    = xor_ff ^ req_rx_byte;
               count_in  = count_ff + CNT_W'(1);
               mem_wr.en = 1'b1;
            end
         end else if ((CNT_W+1)'(count_ff) < limit &&
                      (CNT_W+1)'(count_ff) < (CNT_W+1)'(STORE_DEPTH)) begin
            xor_in    = xor_ff ^ req_rx_byte;
            count_in  = count_ff + CNT_W'(1);
            mem_wr.en = 1'b1;
            if (count_ff == CNT_W'(POS_ID))    id_in   = req_rx_byte;
            if (count_ff == CNT_W'(POS_EVENT)) ev_in   = req_rx_byte;
            if (count_ff == CNT_W'(POS_CODE))  code_in = req_rx_byte;
         end else begin
            // checksum byte closes the frame
            in_frame_in = 1'b0;
            count_in    = '0;
            xor_in      = '0;
            q_push      = 1'b1;
            if (req_rx_byte != xor_ff) begin
               q_cmd.status = ST_CSUM_ERR;
            end else begin
               q_cmd.kind        = slfr_classify(id_ff, ev_ff, code_ff, cfg_ff);
               q_cmd.last_pos    = IDX_W'(limit - (CNT_W+1)'(1));
               busy_in[wbank_ff] = 1'b1;
               wbank_in          = wbank_ff + BANK_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= CFG_RESET;
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
         xor_ff      <= '0;
         wbank_ff    <= '0;
         busy_ff     <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         xor_ff      <= xor_in;
         wbank_ff    <= wbank_in;
         busy_ff     <= busy_in;
         if (csr_we) begin
            case (csr_index)
               REG_SYNC_VALUE:     cfg_ff.sync_value     <= csr_wdata;
               REG_EVENT_MSG_ID:   cfg_ff.event_msg_id   <= csr_wdata;
               REG_BCAST_MSG_ID:   cfg_ff.bcast_msg_id   <= csr_wdata;
               REG_NO_ERROR_CODE:  cfg_ff.no_error_code  <= csr_wdata;
               REG_SEARCH_TO_CODE: cfg_ff.search_to_code <= csr_wdata;
               REG_RX_FAIL_CODE:   cfg_ff.rx_fail_code   <= csr_wdata;
               REG_TX_DONE_CODE:   cfg_ff.tx_done_code   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      id_ff   <= id_in;
      ev_ff   <= ev_in;
      code_ff <= code_in;
   end

endmodule

// ===== rtl/slfr_cmd_fifo.sv =====
// Short queue of frame commands between the front and back parts.
// Depends on slfr_pkg (cmd_type, CMDQ_DEPTH).
module slfr_cmd_fifo
   import slfr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cmd_type  push_cmd,
   output logic     full,
   input  logic     pop,
   output cmd_type  pop_cmd,
   output logic     valid
);

   cmd_type                 q_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CMDQ_CNT_W-1:0]   cnt_ff;
   logic                    do_push, do_pop;

   assign full    = (cnt_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign valid   = (cnt_ff != '0);
   assign pop_cmd = q_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                         : wr_ptr_ff + CMDQ_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                         : rd_ptr_ff + CMDQ_PTR_W'(1);
         end
         if (do_push && !do_pop)      cnt_ff <= cnt_ff + CMDQ_CNT_W'(1);
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - CMDQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) q_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

// ===== rtl/slfr_back.sv =====
// Back part: two-bank frame store, run sequencer and the result output register.
// Depends on slfr_pkg; takes commands from slfr_cmd_fifo and store writes from slfr_front.
module slfr_back
   import slfr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  mem_wr_type          mem_wr,
   input  logic                cmd_valid,
   input  cmd_type             cmd,
   output logic                cmd_pop,
   output release_type         rel,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [BYTE_W-1:0]   rsp_frame_byte,
   output logic [INDEX_W-1:0]  rsp_byte_index,
   output logic [KIND_W-1:0]   rsp_frame_kind,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last
);

   logic [BYTE_W-1:0]   mem [NUM_BANKS][STORE_DEPTH];

   back_state_type      state_ff, state_in;
   logic [BANK_W-1:0]   bank_ff;
   logic [IDX_W-1:0]    last_pos_ff;
   kind_type            kind_ff;
   logic [IDX_W-1:0]    idx_ff;

   logic                rd_pending_ff;
   logic [BYTE_W-1:0]   rd_data_ff;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic                rd_last_ff;
   kind_type            rd_kind_ff;

   logic                out_valid_ff;
   logic [BYTE_W-1:0]   out_byte_ff;
   logic [IDX_W-1:0]    out_idx_ff;
   kind_type            out_kind_ff;
   status_type          out_status_ff;
   logic                out_last_ff;

   logic                out_free, load_rd, load_err, rd_issue, rd_last, start_run;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: if (start_run) state_in = BACK_RUN;
         BACK_RUN:  if (rd_issue && rd_last) state_in = BACK_IDLE;
         default:   state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      out_free  = !out_valid_ff || rsp_pop;
      load_rd   = rd_pending_ff && out_free;
      rd_last   = (idx_ff == last_pos_ff);
      rd_issue  = 1'b0;
      load_err  = 1'b0;
      start_run = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            start_run = cmd_valid && (cmd.status == ST_GOOD);
            load_err  = cmd_valid && (cmd.status != ST_GOOD) && !rd_pending_ff && out_free;
         end
         BACK_RUN: begin
            rd_issue = !rd_pending_ff || load_rd;
         end
         default: ;
      endcase
      cmd_pop   = start_run || load_err;
      rel.valid = rd_issue && rd_last;
      rel.bank  = bank_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BACK_IDLE;
         rd_pending_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rd_issue)     rd_pending_ff <= 1'b1;
         else if (load_rd) rd_pending_ff <= 1'b0;
         if (load_rd || load_err) out_valid_ff <= 1'b1;
         else if (rsp_pop)        out_valid_ff <= 1'b0;
      end
   end

   // frame store: one write port from the front, one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr.en) mem[mem_wr.bank][mem_wr.idx] <= mem_wr.data;
      if (rd_issue)  rd_data_ff <= mem[bank_ff][idx_ff];
   end

   always_ff @(posedge clock) begin
      if (start_run) begin
         bank_ff     <= cmd.bank;
         last_pos_ff <= cmd.last_pos;
         kind_ff     <= cmd.kind;
         idx_ff      <= '0;
      end else if (rd_issue) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (rd_issue) begin
         rd_idx_ff  <= idx_ff;
         rd_last_ff <= rd_last;
         rd_kind_ff <= kind_ff;
      end
      if (load_rd) begin
         out_byte_ff   <= rd_data_ff;
         out_idx_ff    <= rd_idx_ff;
         out_kind_ff   <= rd_kind_ff;
         out_status_ff <= ST_GOOD;
         out_last_ff   <= rd_last_ff;
      end else if (load_err) begin
         out_byte_ff   <= '0;
         out_idx_ff    <= '0;
         out_kind_ff   <= KIND_IGNORE;
         out_status_ff <= cmd.status;
         out_last_ff   <= 1'b1;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_frame_byte = out_byte_ff;
   assign rsp_byte_index = INDEX_W'(out_idx_ff);
   assign rsp_frame_kind = out_kind_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_last       = out_last_ff;

endmodule

// ===== rtl/sync_length_frame_receiver_top.sv =====
// Top level of the sync/length frame receiver: front parser, command queue, back emitter.
// Depends on slfr_pkg, slfr_front, slfr_cmd_fifo and slfr_back.
//
// Usage:
//   Input channel (req_): push one received byte on req_rx_byte; it is taken at a
//   clock edge with req_push high and req_full low. Bytes outside a frame that do not
//   match the sync register are dropped.
//   Result channel (rsp_): while rsp_empty is low the oldest result word is on the
//   rsp_ ports; rsp_pop takes it. A good frame comes out as one word per frame byte
//   (checksum dropped), rsp_last on the final one; a bad checksum or an oversized
//   length gives a single word with rsp_status set and rsp_last high.
//   A good frame's first word passes the command queue, run start, store read and output
//   registers; an error word passes the queue and output register. A run then streams one
//   word per cycle while rsp_pop is held; the single store read port sets that pace.
//   The store has two banks, so the next frame is received while one is emitted;
//   req_full rises when both banks are held or the two-entry command queue is full.
//   Config (csr_): a write with csr_we lands at the clock edge; change registers only
//   while the block is idle. Reset (synchronous) drops any partial frame and pending
//   results and restores the register defaults; there is no store clearing pass.
//   A stalled receiver holds its word; backpressure reaches req_full after the store fills.
module sync_length_frame_receiver_top
   import slfr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [BYTE_W-1:0]   req_rx_byte,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [BYTE_W-1:0]   rsp_frame_byte,
   output logic [INDEX_W-1:0]  rsp_byte_index,
   output logic [KIND_W-1:0]   rsp_frame_kind,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last,
   input  logic                csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]   csr_wdata
);

   logic        q_full, q_push, q_valid, q_pop;
   cmd_type     q_cmd_in, q_cmd_out;
   mem_wr_type  mem_wr;
   release_type rel;

   // Front: parse bytes, check length and checksum, classify
   slfr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_rx_byte (req_rx_byte),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (q_cmd_in),
      .mem_wr      (mem_wr),
      .rel         (rel)
   );

   // Decouple: hold finished frame commands until the back is free
   slfr_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd_in),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (q_cmd_out),
      .valid    (q_valid)
   );

   // Back: stream stored frames or error words to the result port
   slfr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .mem_wr         (mem_wr),
      .cmd_valid      (q_valid),
      .cmd            (q_cmd_out),
      .cmd_pop        (q_pop),
      .rel            (rel),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_byte_index (rsp_byte_index),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== rtl/slfr_checker.sv =====
// Port-level checker for the sync/length frame receiver, bound to the top level.
// Depends on slfr_pkg and sync_length_frame_receiver_top.
module slfr_checker
   import slfr_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_push,
   input logic                req_full,
   input logic [BYTE_W-1:0]   req_rx_byte,
   input logic                rsp_empty,
   input logic                rsp_pop,
   input logic [BYTE_W-1:0]   rsp_frame_byte,
   input logic [INDEX_W-1:0]  rsp_byte_index,
   input logic [KIND_W-1:0]   rsp_frame_kind,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_last,
   input logic                csr_we,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [BYTE_W-1:0]   csr_wdata
);

   // a waiting word holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_frame_byte) &&
         $stable(rsp_byte_index) && $stable(rsp_status) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // error words are single, zeroed and marked last
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_status != ST_GOOD |->
         rsp_last && rsp_frame_byte == '0 && rsp_byte_index == '0 && rsp_frame_kind == '0)
      else $error("malformed error word");

   // good words stay inside the frame store and the kind range
   a_good_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_status == ST_GOOD |->
         rsp_byte_index < INDEX_W'(STORE_DEPTH) && rsp_frame_kind <= KIND_W'(KIND_UNHANDLED))
      else $error("good word out of range");

   // a run whose word was taken without last continues at the next index
   a_run_order: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && rsp_status == ST_GOOD && !rsp_last && !rsp_empty ##1
         !rsp_empty |-> rsp_status == ST_GOOD &&
         rsp_byte_index == $past(rsp_byte_index) + INDEX_W'(1))
      else $error("run index skipped");

   // reset leaves both sides empty and ready
   a_reset: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("not idle after reset");

endmodule

bind sync_length_frame_receiver_top slfr_checker u_slfr_checker (.*);
